@@ sv/bhc_pkg.sv @@
// ----------------------------------------------------------------------------
// bhc_pkg
// shared types and constants of the boiler heating controller
// ----------------------------------------------------------------------------
package bhc_pkg;

    // operating modes, codes 5 to 7 behave as manual
    localparam logic [2:0] MODE_MANUAL   = 3'd0;
    localparam logic [2:0] MODE_SERVICE  = 3'd1;
    localparam logic [2:0] MODE_AUTO     = 3'd2;
    localparam logic [2:0] MODE_HOTWATER = 3'd3;
    localparam logic [2:0] MODE_RADIATOR = 3'd4;

    // configuration register indexes
    localparam logic [2:0] REG_MODE        = 3'd0;
    localparam logic [2:0] REG_RAD_BAND    = 3'd1;
    localparam logic [2:0] REG_HW_BAND     = 3'd2;
    localparam logic [2:0] REG_BURN_BAND   = 3'd3;
    localparam logic [2:0] REG_RAD_OFFSET  = 3'd4;
    localparam logic [2:0] REG_HW_BOOST    = 3'd5;
    localparam logic [2:0] REG_MIN_DEFICIT = 3'd6;
    localparam logic [2:0] REG_MANUAL      = 3'd7;

    // floor(n / 1000) = (n * DIV_RECIP) >> DIV_SHIFT, exact for n < 2**30
    localparam int          DIV_SHIFT = 38;
    localparam logic [28:0] DIV_RECIP = 29'd274877907;

    typedef struct packed {
        logic [2:0]         mode;
        logic [9:0]         rad_band;
        logic [9:0]         hw_band;
        logic [9:0]         burn_band;
        logic signed [10:0] rad_offset;
        logic signed [10:0] hotwater_boost;
        logic [9:0]         hw_min_deficit;
        logic [31:0]        manual_setpoints;
    } cfg_t;

    typedef struct packed {
        logic signed [15:0] boiler_temp;
        logic signed [15:0] tank_temp;
        logic signed [15:0] outdoor_temp;
        logic               curve_valid;
        logic signed [15:0] curve_threshold;
        logic [14:0]        curve_slew;
        logic               schedule_hotwater_valid;
        logic signed [15:0] schedule_hotwater_temp;
        logic               request_set;
        logic signed [15:0] request_temp;
    } item_t;

    typedef struct packed {
        logic               radiator_flag;
        logic               hotwater_flag;
        logic               burner_flag;
        logic               request_active;
        logic signed [15:0] request_setpoint;
        logic [7:0]         startup_count;
        logic [15:0]        min_on_count;
        logic [15:0]        min_off_count;
    } state_t;

    typedef struct packed {
        logic               radiator_drive;
        logic               hotwater_drive;
        logic               burner_drive;
        logic signed [15:0] radiator_target;
        logic signed [15:0] hotwater_target;
        logic signed [15:0] boiler_target;
        logic               request_pending;
    } result_t;

endpackage

@@ sv/bhc_tick.sv @@
// ----------------------------------------------------------------------------
// bhc_tick
// control rules of one tick: setpoints, hysteresis, burner timers and cutoffs
// ----------------------------------------------------------------------------
module bhc_tick import bhc_pkg::*; #(
    parameter int BOILER_MAX_TEMP   = 800,
    parameter int MIN_ON_TICKS      = 60,
    parameter int MIN_OFF_TICKS     = 60,
    parameter int HOTWATER_PRIORITY = 0
) (
    input  cfg_t               cfg,
    input  item_t              item,
    input  logic signed [15:0] curve_scaled,    // (threshold - outdoor) * slew / 1000
    input  state_t             state,
    output state_t             state_next,
    output result_t            result
);

    localparam logic signed [16:0] BMAX17   = 17'(BOILER_MAX_TEMP);
    localparam logic [15:0]        BMAX16   = 16'(BOILER_MAX_TEMP);
    localparam logic [15:0]        ON_LOAD  = 16'(MIN_ON_TICKS);
    localparam logic [15:0]        OFF_LOAD = 16'(MIN_OFF_TICKS);

    logic               service;
    logic               curve;
    logic               rad_f;
    logic               hw_f;
    logic               burn_f;
    logic               req_act;
    logic signed [15:0] req_sp;
    logic signed [15:0] rad_sp;
    logic signed [15:0] hw_sp;
    logic signed [15:0] boil_sp;
    logic signed [15:0] err_c;
    logic signed [15:0] ehw;
    logic signed [15:0] ehw_diff;
    logic signed [15:0] err_b;
    logic signed [17:0] err_c_x;
    logic signed [17:0] ehw_x;
    logic signed [17:0] ehw_diff_x;
    logic signed [17:0] err_b_x;
    logic signed [17:0] hr_pos;
    logic signed [17:0] hh_pos;
    logic signed [17:0] hb_pos;
    logic signed [16:0] btemp_x;
    logic [7:0]         startup;
    logic [15:0]        on_cnt;
    logic [15:0]        off_cnt;

    always_comb begin
        hr_pos  = {8'b0, cfg.rad_band};
        hh_pos  = {8'b0, cfg.hw_band};
        hb_pos  = {8'b0, cfg.burn_band};
        btemp_x = {item.boiler_temp[15], item.boiler_temp};

        service = (cfg.mode == MODE_SERVICE);
        curve   = ((cfg.mode == MODE_AUTO) || (cfg.mode == MODE_RADIATOR)) && item.curve_valid;
        rad_sp  = '0;
        hw_sp   = '0;

        unique case (cfg.mode)
            MODE_SERVICE: begin
            end
            MODE_AUTO, MODE_HOTWATER: begin
                if (item.schedule_hotwater_valid) begin
                    hw_sp = item.schedule_hotwater_temp;
                end
            end
            MODE_RADIATOR: begin
            end
            default: begin
                rad_sp = cfg.manual_setpoints[15:0];
                hw_sp  = cfg.manual_setpoints[31:16];
            end
        endcase

        // radiator demand
        err_c   = item.curve_threshold - item.outdoor_temp;
        err_c_x = {{2{err_c[15]}}, err_c};
        rad_f   = state.radiator_flag;
        if (curve) begin
            if (err_c_x > hr_pos) begin
                rad_f = 1'b1;
            end
            if (err_c_x < -hr_pos) begin
                rad_f = 1'b0;
            end
            if (rad_f) begin
                rad_sp = item.curve_threshold + curve_scaled
                       + {{5{cfg.rad_offset[10]}}, cfg.rad_offset};
            end
        end else begin
            rad_f = (rad_sp > 16'sd0);
        end

        // hot water request
        req_act = state.request_active;
        req_sp  = state.request_setpoint;
        if (item.request_set) begin
            req_act = 1'b1;
            req_sp  = item.request_temp;
        end
        if (req_act) begin
            hw_sp = req_sp;
        end

        // hot water demand
        ehw   = hw_sp - item.tank_temp;
        ehw_x = {{2{ehw[15]}}, ehw};
        hw_f  = state.hotwater_flag;
        if ((ehw_x > hh_pos) || req_act) begin
            hw_f = 1'b1;
        end
        if (ehw_x < -hh_pos) begin
            hw_f    = 1'b0;
            req_act = 1'b0;
        end

        if ((HOTWATER_PRIORITY != 0) && hw_f) begin
            rad_f = 1'b0;
        end

        // burner demand
        if (hw_f) begin
            if (!cfg.hotwater_boost[10]) begin
                boil_sp = hw_sp + {{5{cfg.hotwater_boost[10]}}, cfg.hotwater_boost};
            end else begin
                boil_sp = BMAX16 - {6'b0, cfg.burn_band};
            end
        end else begin
            boil_sp = rad_sp;
        end
        err_b   = boil_sp - item.boiler_temp;
        err_b_x = {{2{err_b[15]}}, err_b};
        burn_f  = state.burner_flag;
        if (err_b_x > hb_pos) begin
            burn_f = 1'b1;
        end
        if (err_b_x < -hb_pos) begin
            burn_f = 1'b0;
        end

        // minimum hot water deficit at burner start
        ehw_diff   = ehw - {6'b0, cfg.hw_min_deficit};
        ehw_diff_x = {{2{ehw_diff[15]}}, ehw_diff};
        if (hw_f && !state.burner_flag && burn_f && (ehw_diff_x < -hh_pos)) begin
            hw_f    = 1'b0;
            req_act = 1'b0;
            burn_f  = 1'b0;
        end

        // start-up lockout
        startup = state.startup_count;
        if (startup != 8'd0) begin
            startup = startup - 8'd1;
            rad_f   = 1'b0;
            hw_f    = 1'b0;
            burn_f  = 1'b0;
        end

        // minimum on and off times
        on_cnt  = (state.min_on_count != 16'd0) ? state.min_on_count - 16'd1 : 16'd0;
        off_cnt = (state.min_off_count != 16'd0) ? state.min_off_count - 16'd1 : 16'd0;
        if (burn_f) begin
            if (off_cnt != 16'd0) begin
                burn_f = 1'b0;
            end
        end else begin
            if (on_cnt != 16'd0) begin
                burn_f = 1'b1;
            end
        end
        if (burn_f && !state.burner_flag) begin
            on_cnt = ON_LOAD;
        end
        if (!burn_f && state.burner_flag) begin
            off_cnt = OFF_LOAD;
        end

        // over-temperature cutoff
        if (btemp_x > BMAX17) begin
            burn_f = 1'b0;
        end

        if (service) begin
            rad_f  = 1'b1;
            hw_f   = 1'b0;
            burn_f = 1'b1;
        end

        state_next.radiator_flag    = rad_f;
        state_next.hotwater_flag    = hw_f;
        state_next.burner_flag      = burn_f;
        state_next.request_active   = req_act;
        state_next.request_setpoint = req_sp;
        state_next.startup_count    = startup;
        state_next.min_on_count     = on_cnt;
        state_next.min_off_count    = off_cnt;

        result.radiator_drive  = rad_f;
        result.hotwater_drive  = hw_f;
        result.burner_drive    = burn_f;
        result.radiator_target = rad_sp;
        result.hotwater_target = hw_sp;
        result.boiler_target   = boil_sp;
        result.request_pending = req_act;
    end

endmodule

@@ sv/boiler_heating_controller.sv @@
// ----------------------------------------------------------------------------
// boiler_heating_controller
// one control tick per request: setpoints, hysteresis and burner supervision
// ----------------------------------------------------------------------------
// Usage:
//   s_ channel carries one tick (temperatures, curve, schedule, hot water
//   request); m_ channel returns the drives, the three setpoints and the
//   request status. cfg_ channel writes the mode, hysteresis bands, offsets
//   and manual setpoints; it is always ready and should be written while no
//   request is in flight.
//   Three register stages: curve product, scaling by 1/1000 through a
//   reciprocal multiply, then the tick rules with the result register.
//   One request per cycle is sustained while m_ does not stall. Controller state
//   advances as each request moves into the result register, so back-to-back
//   ticks see the state of the one before. Reset clears the configuration,
//   drives, timers and pipeline, and loads the start-up lockout. A stalled m_
//   side holds its result; the stages upstream keep filling until all three
//   are occupied, then s_tready drops.
// ----------------------------------------------------------------------------
module boiler_heating_controller import bhc_pkg::*; #(
    parameter int BOILER_MAX_TEMP   = 800,
    parameter int MIN_ON_TICKS      = 60,
    parameter int MIN_OFF_TICKS     = 60,
    parameter int STARTUP_TICKS     = 10,
    parameter int HOTWATER_PRIORITY = 0
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    // boiler_temp, tank_temp, outdoor_temp, curve_valid, curve_threshold,
    // curve_slew, schedule_hotwater_valid, schedule_hotwater_temp,
    // request_set, request_temp, zero pad
    input  logic [119:0] s_tdata,
    output logic         m_tvalid,
    input  logic         m_tready,
    // radiator_drive, hotwater_drive, burner_drive, radiator_target,
    // hotwater_target, boiler_target, request_pending, zero pad
    output logic [55:0]  m_tdata,
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic [2:0]   cfg_index,
    input  logic [31:0]  cfg_data
);

    cfg_t               cfg_reg;
    item_t              s_item;
    logic signed [15:0] err_in;
    logic [15:0]        err_mag;
    logic [30:0]        prod_full;
    logic [58:0]        recip_full;
    logic [15:0]        quot_mag;

    logic               a_valid_reg;
    item_t              a_item_reg;
    logic               a_neg_reg;
    logic [29:0]        a_prod_reg;
    logic               b_valid_reg;
    item_t              b_item_reg;
    logic signed [15:0] b_quot_reg;
    logic               b_quot_next;
    logic               out_valid_reg;
    result_t            out_res_reg;
    result_t            res_next;
    state_t             state_reg;
    state_t             state_next;

    logic               out_load;
    logic               b_load;
    logic               a_load;

    assign s_item.boiler_temp             = s_tdata[15:0];
    assign s_item.tank_temp               = s_tdata[31:16];
    assign s_item.outdoor_temp            = s_tdata[47:32];
    assign s_item.curve_valid             = s_tdata[48];
    assign s_item.curve_threshold         = s_tdata[64:49];
    assign s_item.curve_slew              = s_tdata[79:65];
    assign s_item.schedule_hotwater_valid = s_tdata[80];
    assign s_item.schedule_hotwater_temp  = s_tdata[96:81];
    assign s_item.request_set             = s_tdata[97];
    assign s_item.request_temp            = s_tdata[113:98];

    // stage flow control
    assign out_load = !out_valid_reg || m_tready;
    assign b_load   = !b_valid_reg || out_load;
    assign a_load   = !a_valid_reg || b_load;
    assign s_tready = a_load;
    assign cfg_ready = 1'b1;

    // curve product magnitude, sign kept aside for truncation toward zero
    assign err_in    = s_item.curve_threshold - s_item.outdoor_temp;
    assign err_mag   = err_in[15] ? 16'd0 - err_in : err_in;
    assign prod_full = err_mag * s_item.curve_slew;

    assign recip_full  = a_prod_reg * DIV_RECIP;
    assign quot_mag    = recip_full[DIV_SHIFT +: 16];
    assign b_quot_next = a_neg_reg;

    bhc_tick #(
        .BOILER_MAX_TEMP   (BOILER_MAX_TEMP),
        .MIN_ON_TICKS      (MIN_ON_TICKS),
        .MIN_OFF_TICKS     (MIN_OFF_TICKS),
        .HOTWATER_PRIORITY (HOTWATER_PRIORITY)
    ) u_tick (
        .cfg          (cfg_reg),
        .item         (b_item_reg),
        .curve_scaled (b_quot_reg),
        .state        (state_reg),
        .state_next   (state_next),
        .result       (res_next)
    );

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= '0;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                REG_MODE:        cfg_reg.mode             <= cfg_data[2:0];
                REG_RAD_BAND:    cfg_reg.rad_band         <= cfg_data[9:0];
                REG_HW_BAND:     cfg_reg.hw_band          <= cfg_data[9:0];
                REG_BURN_BAND:   cfg_reg.burn_band        <= cfg_data[9:0];
                REG_RAD_OFFSET:  cfg_reg.rad_offset       <= cfg_data[10:0];
                REG_HW_BOOST:    cfg_reg.hotwater_boost   <= cfg_data[10:0];
                REG_MIN_DEFICIT: cfg_reg.hw_min_deficit   <= cfg_data[9:0];
                REG_MANUAL:      cfg_reg.manual_setpoints <= cfg_data;
                default: begin
                end
            endcase
        end
    end

    // control state and stage valids
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_valid_reg   <= 1'b0;
            b_valid_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
            state_reg     <= '{
                radiator_flag:    1'b0,
                hotwater_flag:    1'b0,
                burner_flag:      1'b0,
                request_active:   1'b0,
                request_setpoint: 16'sd0,
                startup_count:    8'(STARTUP_TICKS),
                min_on_count:     16'd0,
                min_off_count:    16'd0
            };
        end else begin
            if (a_load) begin
                a_valid_reg <= s_tvalid;
            end
            if (b_load) begin
                b_valid_reg <= a_valid_reg;
            end
            if (out_load) begin
                out_valid_reg <= b_valid_reg;
            end
            if (out_load && b_valid_reg) begin
                state_reg <= state_next;
            end
        end
    end

    // payload
    always_ff @(posedge aclk) begin
        if (a_load) begin
            a_item_reg <= s_item;
            a_neg_reg  <= err_in[15];
            a_prod_reg <= prod_full[29:0];
        end
        if (b_load) begin
            b_item_reg <= a_item_reg;
            b_quot_reg <= b_quot_next ? 16'd0 - quot_mag : quot_mag;
        end
        if (out_load) begin
            out_res_reg <= res_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {4'b0,
                       out_res_reg.request_pending,
                       out_res_reg.boiler_target,
                       out_res_reg.hotwater_target,
                       out_res_reg.radiator_target,
                       out_res_reg.burner_drive,
                       out_res_reg.hotwater_drive,
                       out_res_reg.radiator_drive};

endmodule

@@ sv/bhc_checker.sv @@
// ----------------------------------------------------------------------------
// bhc_checker
// port-level checks of the boiler heating controller
// ----------------------------------------------------------------------------
module bhc_checker (
    input logic         aclk,
    input logic         aresetn,
    input logic         s_tvalid,
    input logic         s_tready,
    input logic         m_tvalid,
    input logic         m_tready,
    input logic [55:0]  m_tdata
);

    logic [2:0] inflight_reg;
    logic       s_fire;
    logic       m_fire;

    assign s_fire = s_tvalid && s_tready;
    assign m_fire = m_tvalid && m_tready;

    // requests taken but not yet returned
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            inflight_reg <= 3'd0;
        end else begin
            inflight_reg <= inflight_reg + {2'b0, s_fire} - {2'b0, m_fire};
        end
    end

    a_reset_clears_out: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

    a_stall_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("stalled result changed");

    a_no_invented: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> inflight_reg != 3'd0)
        else $error("result without a pending request");

    a_depth: assert property (@(posedge aclk) disable iff (!aresetn)
        s_fire |-> inflight_reg < 3'd3 || m_fire)
        else $error("more requests in flight than stages");

endmodule

bind boiler_heating_controller bhc_checker u_bhc_checker (.*);
